// File: sv/differential_steer_pid_defines.svh
// assertion macros shared by the steering controller
`ifndef DIFFERENTIAL_STEER_PID_DEFINES_SVH
`define DIFFERENTIAL_STEER_PID_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define DSTEER_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define DSTEER_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dsteer_pkg.sv
package dsteer_pkg;

  // field and datapath widths
  localparam int ErrW    = 8;
  localparam int BiasW   = ErrW + 1;
  localparam int DeltaW  = BiasW + 1;
  localparam int IntegW  = 24;
  localparam int GainW   = 16;
  localparam int DriveW  = 16;
  localparam int FracW   = 4;
  localparam int ProdPW  = GainW + 1 + BiasW;
  localparam int ProdIW  = GainW + 1 + IntegW;
  localparam int ProdDW  = GainW + 1 + DeltaW;
  localparam int SumW    = ProdIW + 2;
  localparam int SteerW  = SumW - FracW;
  localparam int MixW    = SteerW + 1;
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;

  // register map, word index
  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_BASE_SPEED = 3'd3,
    REG_PWM_MAX    = 3'd4,
    REG_SETPOINT   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GainW-1:0]       gain_p;
    logic [GainW-1:0]       gain_i;
    logic [GainW-1:0]       gain_d;
    logic [DriveW-1:0]      base_speed;
    logic [DriveW-1:0]      pwm_max;
    logic signed [ErrW-1:0] setpoint;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    gain_p:     16'd1600,
    gain_i:     16'd0,
    gain_d:     16'd0,
    base_speed: 16'd7200,
    pwm_max:    16'd7200,
    setpoint:   8'sd0
  };

  // bias stage result
  typedef struct packed {
    logic signed [BiasW-1:0]  bias;
    logic signed [DeltaW-1:0] delta;
    logic signed [IntegW-1:0] integ;
  } bias_t;

  // product stage result
  typedef struct packed {
    logic signed [ProdPW-1:0] p;
    logic signed [ProdIW-1:0] i;
    logic signed [ProdDW-1:0] d;
  } prod_t;

  // per-stage load strobes
  typedef struct packed {
    logic in;
    logic bias;
    logic mult;
    logic steer;
    logic out;
  } pipe_ld_t;

endpackage

// File: sv/dsteer_cfg.sv
module dsteer_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dsteer_pkg::CfgAddrW-1:0] paddr,
  input  logic [dsteer_pkg::CfgDataW-1:0] pwdata,
  output logic [dsteer_pkg::CfgDataW-1:0] prdata,
  output logic                           pready,
  output dsteer_pkg::cfg_t               cfg
);
  import dsteer_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CfgAddrW-1:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // register write decode, out-of-map words dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_GAIN_P:     cfg_nxt.gain_p     = pwdata[GainW-1:0];
        REG_GAIN_I:     cfg_nxt.gain_i     = pwdata[GainW-1:0];
        REG_GAIN_D:     cfg_nxt.gain_d     = pwdata[GainW-1:0];
        REG_BASE_SPEED: cfg_nxt.base_speed = pwdata[DriveW-1:0];
        REG_PWM_MAX:    cfg_nxt.pwm_max    = pwdata[DriveW-1:0];
        REG_SETPOINT:   cfg_nxt.setpoint   = $signed(pwdata[ErrW-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_GAIN_P:     prdata = {(CfgDataW-GainW)'(0), cfg_r.gain_p};
      REG_GAIN_I:     prdata = {(CfgDataW-GainW)'(0), cfg_r.gain_i};
      REG_GAIN_D:     prdata = {(CfgDataW-GainW)'(0), cfg_r.gain_d};
      REG_BASE_SPEED: prdata = {(CfgDataW-DriveW)'(0), cfg_r.base_speed};
      REG_PWM_MAX:    prdata = {(CfgDataW-DriveW)'(0), cfg_r.pwm_max};
      REG_SETPOINT:   prdata = {{(CfgDataW-ErrW){cfg_r.setpoint[ErrW-1]}}, cfg_r.setpoint};
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: sv/dsteer_bias.sv
module dsteer_bias (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic signed [dsteer_pkg::ErrW-1:0]  err,
  input  logic signed [dsteer_pkg::ErrW-1:0]  setpoint,
  output dsteer_pkg::bias_t                   stage
);
  import dsteer_pkg::*;

  logic signed [IntegW-1:0] integ_r;
  logic signed [IntegW-1:0] integ_nxt;
  logic signed [BiasW-1:0]  prev_r;
  logic signed [BiasW-1:0]  bias;
  logic signed [IntegW:0]   acc;
  bias_t                    stage_r;
  bias_t                    stage_nxt;

  // bias and saturating running sum
  always_comb begin
    bias = BiasW'(err) - BiasW'(setpoint);
    acc  = (IntegW+1)'(integ_r) + (IntegW+1)'(bias);
    if (acc[IntegW] != acc[IntegW-1]) begin
      integ_nxt = {acc[IntegW], {(IntegW-1){~acc[IntegW]}}};
    end else begin
      integ_nxt = acc[IntegW-1:0];
    end
    stage_nxt.bias  = bias;
    stage_nxt.delta = DeltaW'(bias) - DeltaW'(prev_r);
    stage_nxt.integ = integ_nxt;
  end

  // controller state, one update per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (load) begin
      integ_r <= integ_nxt;
      prev_r  <= bias;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage = stage_r;

endmodule

// File: sv/dsteer_mult.sv
module dsteer_mult (
  input  logic                             clk,
  input  logic                             load,
  input  dsteer_pkg::bias_t                stage,
  input  logic [dsteer_pkg::GainW-1:0]     gain_p,
  input  logic [dsteer_pkg::GainW-1:0]     gain_i,
  input  logic [dsteer_pkg::GainW-1:0]     gain_d,
  output dsteer_pkg::prod_t                prod
);
  import dsteer_pkg::*;

  prod_t prod_r;
  prod_t prod_nxt;

  // three gain products, side by side
  always_comb begin
    prod_nxt.p = ProdPW'($signed({1'b0, gain_p})) * ProdPW'(stage.bias);
    prod_nxt.i = ProdIW'($signed({1'b0, gain_i})) * ProdIW'(stage.integ);
    prod_nxt.d = ProdDW'($signed({1'b0, gain_d})) * ProdDW'(stage.delta);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// File: sv/dsteer_mix.sv
module dsteer_mix (
  input  logic                              clk,
  input  dsteer_pkg::pipe_ld_t              ld,
  input  dsteer_pkg::prod_t                 prod,
  input  logic [dsteer_pkg::DriveW-1:0]     base_speed,
  input  logic [dsteer_pkg::DriveW-1:0]     pwm_max,
  output logic [2*dsteer_pkg::DriveW-1:0]   drive
);
  import dsteer_pkg::*;

  logic signed [SumW-1:0]   sum;
  logic signed [SteerW-1:0] steer_r;
  logic signed [MixW-1:0]   left_mix;
  logic signed [MixW-1:0]   right_mix;
  logic [2*DriveW-1:0]      drive_r;
  logic [2*DriveW-1:0]      drive_nxt;

  // floor to zero, then cap at the limit
  function automatic logic [DriveW-1:0] clamp_drive(
    input logic signed [MixW-1:0] v,
    input logic [DriveW-1:0]      lim
  );
    logic [MixW-1:0] vu;
    vu = $unsigned(v);
    if (v[MixW-1]) begin
      return '0;
    end else if (vu > {(MixW-DriveW)'(0), lim}) begin
      return lim;
    end else begin
      return vu[DriveW-1:0];
    end
  endfunction

  // steering sum, arithmetic shift drops the fraction bits
  assign sum = SumW'(prod.p) + SumW'(prod.i) + SumW'(prod.d);

  always_ff @(posedge clk) begin
    if (ld.steer) begin
      steer_r <= SteerW'(sum >>> FracW);
    end
  end

  // wheel mix and clamp
  always_comb begin
    left_mix  = MixW'($signed({1'b0, base_speed})) + MixW'(steer_r);
    right_mix = MixW'($signed({1'b0, base_speed})) - MixW'(steer_r);
    drive_nxt = {clamp_drive(right_mix, pwm_max), clamp_drive(left_mix, pwm_max)};
  end

  always_ff @(posedge clk) begin
    if (ld.out) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive = drive_r;

endmodule

// File: sv/differential_steer_pid.sv
// Steering controller for a two-wheel line follower.
// Input stream: one beat per control tick, in_tdata[7:0] = signed line error.
// Output stream: one beat per input beat, in order; out_tdata[15:0] = left
// drive, out_tdata[31:16] = right drive, each clamped to 0..pwm_max.
// Config: APB-style port, word registers at byte offsets 0x00 gain_p,
// 0x04 gain_i, 0x08 gain_d, 0x0C base_speed, 0x10 pwm_max, 0x14 setpoint;
// write only while no beat is in flight.
// Pipeline: five register stages (input, bias/integral, products, steering
// sum, clamped drives). Throughput: one beat per cycle while out_tready is
// high; the integral and previous bias update together when the bias stage
// loads, so ticks may follow back to back.
// Reset: gains, speeds and setpoint return to their defaults, the integral
// and previous bias clear to zero and all stages empty.
// Stall: with out_tready low, the result holds and earlier stages keep
// filling; in_tready drops only once all five stages hold a beat.
module differential_steer_pid (
  input  logic                                clk,
  input  logic                                rst_n,
  // slave side
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] line_error
  // master side
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // [15:0] left_drive, [31:16] right_drive
  // config
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [dsteer_pkg::CfgAddrW-1:0]     cfg_paddr,
  input  logic [dsteer_pkg::CfgDataW-1:0]     cfg_pwdata,
  output logic [dsteer_pkg::CfgDataW-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import dsteer_pkg::*;
  `include "differential_steer_pid_defines.svh"

  cfg_t                 cfg;
  pipe_ld_t             ld;
  logic [4:0]           vld_r;
  logic [4:0]           vld_nxt;
  logic [4:0]           free;
  logic signed [ErrW-1:0] err_r;
  bias_t                bias_stg;
  prod_t                prod;
  logic [2*DriveW-1:0]  drive;

  dsteer_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // stage occupancy: a stage takes a beat when empty or when it passes one on
  always_comb begin
    free[4]  = !vld_r[4] || out_tready;
    ld.out   = vld_r[3] & free[4];
    free[3]  = !vld_r[3] || ld.out;
    ld.steer = vld_r[2] & free[3];
    free[2]  = !vld_r[2] || ld.steer;
    ld.mult  = vld_r[1] & free[2];
    free[1]  = !vld_r[1] || ld.mult;
    ld.bias  = vld_r[0] & free[1];
    free[0]  = !vld_r[0] || ld.bias;
    ld.in    = in_tvalid & free[0];

    vld_nxt[4] = ld.out   | (vld_r[4] & ~out_tready);
    vld_nxt[3] = ld.steer | (vld_r[3] & ~ld.out);
    vld_nxt[2] = ld.mult  | (vld_r[2] & ~ld.steer);
    vld_nxt[1] = ld.bias  | (vld_r[1] & ~ld.mult);
    vld_nxt[0] = ld.in    | (vld_r[0] & ~ld.bias);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (ld.in) begin
      err_r <= $signed(in_tdata[ErrW-1:0]);
    end
  end

  dsteer_bias u_bias (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ld.bias),
    .err      (err_r),
    .setpoint (cfg.setpoint),
    .stage    (bias_stg)
  );

  dsteer_mult u_mult (
    .clk    (clk),
    .load   (ld.mult),
    .stage  (bias_stg),
    .gain_p (cfg.gain_p),
    .gain_i (cfg.gain_i),
    .gain_d (cfg.gain_d),
    .prod   (prod)
  );

  dsteer_mix u_mix (
    .clk        (clk),
    .ld         (ld),
    .prod       (prod),
    .base_speed (cfg.base_speed),
    .pwm_max    (cfg.pwm_max),
    .drive      (drive)
  );

  assign in_tready  = free[0];
  assign out_tvalid = vld_r[4];
  assign out_tdata  = drive;

  // checks
  `DSTEER_ASSERT_IMP(a_drive_capped, out_tvalid,
    (out_tdata[15:0] <= cfg.pwm_max) && (out_tdata[31:16] <= cfg.pwm_max),
    "wheel drive above pwm_max")
  `DSTEER_ASSERT_NXT(a_prod_held, vld_r[2] && !ld.steer,
    vld_r[2] && $stable(prod), "held product stage lost or changed its beat")
  `DSTEER_ASSERT_NXT(a_err_held, vld_r[0] && !ld.bias,
    vld_r[0] && $stable(err_r), "held input stage lost or changed its beat")

endmodule
